// ----- hdl/sgb_pkg.sv -----
// Shared types and constants for the sphere grid bilinear sampler.
`timescale 1ns / 1ps
package sgb_pkg;

  // Field widths of the input, output and configuration beats.
  localparam int ACT_W   = 3;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 6;
  localparam int DATA_W  = 32;
  localparam int ANGLE_W = 32;
  localparam int CPT_W   = 21;
  localparam int PCNT_W  = 8;
  localparam int TCNT_W  = 7;
  localparam int CFG_IDX_W = 2;

  // Scaled angle: integer cell index and Q0.16 weight.
  localparam int PROD_W  = ANGLE_W + CPT_W;
  localparam int IDX_W   = PROD_W - 40;
  localparam int ALPHA_W = 16;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_WR_CUR = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WR_NXT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SWAP   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SAMPLE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CPT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PCNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TCNT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CPT_W-1:0] CPT_RESET = 21'd32768;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // One classified command handed from front to back.
  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic [PCNT_W-1:0]  col_lo;
    logic [PCNT_W-1:0]  col_hi;
    logic [TCNT_W-1:0]  row_lo;
    logic [TCNT_W-1:0]  row_hi;
    logic [ALPHA_W-1:0] alpha_phi;
    logic [ALPHA_W-1:0] alpha_theta;
    logic [DATA_W-1:0]  value;
    logic               flipped;
  } sgb_cmd_t;

endpackage

// ----- hdl/sgb_front.sv -----
// Front end: accepts beats, reflects and scales angles, resolves cell indexes.
`timescale 1ns / 1ps
module sgb_front import sgb_pkg::*; #(
  parameter int PHI_CELLS   = 128,
  parameter int THETA_CELLS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACT_W-1:0]    in_action,
  input  logic [COL_W-1:0]    in_col,
  input  logic [ROW_W-1:0]    in_row,
  input  logic [DATA_W-1:0]   in_value,
  input  logic [ANGLE_W-1:0]  in_phi_angle,
  input  logic [ANGLE_W-1:0]  in_theta_angle,
  input  logic [CPT_W-1:0]    cells_per_turn,
  input  logic [PCNT_W-1:0]   phi_count,
  input  logic [TCNT_W-1:0]   theta_count,
  output logic                push,
  output sgb_cmd_t            push_cmd,
  input  logic                q_full
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_DIV  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  localparam int CNT_W = $clog2(IDX_W + 1);

  fstate_t             state_r, state_nxt;
  logic [ACT_W-1:0]    act_r;
  logic [PCNT_W-1:0]   col_r;
  logic [TCNT_W-1:0]   row_r;
  logic [DATA_W-1:0]   value_r;
  logic [ANGLE_W-1:0]  phi_r, theta_r;
  logic                flip_r;
  logic [IDX_W-1:0]    pidx_r, tidx_r;
  logic [ALPHA_W-1:0]  ap_r, at_r;
  logic [PCNT_W:0]     rem_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [PROD_W-1:0]   np, nt;
  logic [PCNT_W:0]     rem_shift;
  logic [PCNT_W:0]     rem_next;
  logic                accept;
  logic                reflect;
  logic [PCNT_W-1:0]   col_hi;
  logic [IDX_W:0]      tidx_inc;
  logic [TCNT_W-1:0]   last_row;
  logic [TCNT_W-1:0]   row_lo, row_hi;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != F_IDLE);
  assign reflect  = in_theta_angle > 32'h8000_0000;

  // Scale both angles by cells per turn.
  assign np = {{CPT_W{1'b0}}, phi_r} * {{ANGLE_W{1'b0}}, cells_per_turn};
  assign nt = {{CPT_W{1'b0}}, theta_r} * {{ANGLE_W{1'b0}}, cells_per_turn};

  // One restoring step of the column index modulo the column count.
  always_comb begin
    rem_shift = {rem_r[PCNT_W-1:0], pidx_r[IDX_W-1]};
    if (rem_shift >= {1'b0, phi_count}) begin
      rem_next = rem_shift - {1'b0, phi_count};
    end else begin
      rem_next = rem_shift;
    end
  end

  // Neighbor column wraps; rows clamp to the last row in use.
  always_comb begin
    if (rem_r[PCNT_W-1:0] + 8'd1 == phi_count) begin
      col_hi = '0;
    end else begin
      col_hi = rem_r[PCNT_W-1:0] + 8'd1;
    end
    last_row = theta_count - 7'd1;
    tidx_inc = {1'b0, tidx_r} + {{IDX_W{1'b0}}, 1'b1};
    row_lo   = (tidx_r > {{(IDX_W-TCNT_W){1'b0}}, last_row}) ? last_row : tidx_r[TCNT_W-1:0];
    row_hi   = (tidx_inc > {{(IDX_W+1-TCNT_W){1'b0}}, last_row}) ? last_row
                                                                   : tidx_inc[TCNT_W-1:0];
  end

  // Command presented to the queue.
  always_comb begin
    push_cmd = '0;
    push_cmd.act   = act_r;
    push_cmd.value = value_r;
    if (act_r == ACT_SAMPLE) begin
      push_cmd.col_lo      = rem_r[PCNT_W-1:0];
      push_cmd.col_hi      = col_hi;
      push_cmd.row_lo      = row_lo;
      push_cmd.row_hi      = row_hi;
      push_cmd.alpha_phi   = ap_r;
      push_cmd.alpha_theta = at_r;
      push_cmd.flipped     = flip_r;
    end else begin
      push_cmd.col_lo = col_r;
      push_cmd.row_lo = row_r;
    end
  end

  assign push = (state_r == F_PUSH) && !q_full;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_SAMPLE: state_nxt = F_MUL;
            ACT_WR_CUR, ACT_WR_NXT, ACT_SWAP, ACT_READ: state_nxt = F_PUSH;
            default: state_nxt = F_IDLE;
          endcase
        end
      end
      F_MUL:  state_nxt = F_DIV;
      F_DIV:  if (cnt_r == CNT_W'(IDX_W - 1)) state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= in_action;
      col_r   <= PCNT_W'(32'(in_col) % PHI_CELLS);
      row_r   <= TCNT_W'(32'(in_row) % THETA_CELLS);
      value_r <= in_value;
      flip_r  <= reflect;
      theta_r <= reflect ? (32'd0 - in_theta_angle) : in_theta_angle;
      phi_r   <= reflect ? (in_phi_angle + 32'h8000_0000) : in_phi_angle;
    end
    if (state_r == F_MUL) begin
      pidx_r <= np[PROD_W-1:40];
      tidx_r <= nt[PROD_W-1:40];
      ap_r   <= np[39:24];
      at_r   <= nt[39:24];
      rem_r  <= '0;
      cnt_r  <= '0;
    end else if (state_r == F_DIV) begin
      rem_r  <= rem_next;
      pidx_r <= {pidx_r[IDX_W-2:0], 1'b0};
      cnt_r  <= cnt_r + CNT_W'(1);
    end
  end

endmodule

// ----- hdl/sgb_queue.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module sgb_queue import sgb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  sgb_cmd_t  push_cmd,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output sgb_cmd_t  head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  sgb_cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]       count_r;

  assign full  = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (push && !pop) begin
        count_r <= count_r + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PTR_W+1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// ----- hdl/sgb_back.sv -----
// Back end: grid memory, bank select, four-cell fetch and bilinear blend.
`timescale 1ns / 1ps
module sgb_back import sgb_pkg::*; #(
  parameter int PHI_CELLS   = 128,
  parameter int THETA_CELLS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  sgb_cmd_t            q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DATA_W-1:0]   out_result_value,
  output logic                out_pole_flipped
);

  localparam int BANK  = PHI_CELLS * THETA_CELLS;
  localparam int DEPTH = 2 * BANK;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [14:0] {
    B_IDLE = 15'b000000000000001,
    B_WR   = 15'b000000000000010,
    B_SWAP = 15'b000000000000100,
    B_RD0  = 15'b000000000001000,
    B_RD1  = 15'b000000000010000,
    B_RD2  = 15'b000000000100000,
    B_RD3  = 15'b000000001000000,
    B_RD4  = 15'b000000010000000,
    B_M0   = 15'b000000100000000,
    B_A0   = 15'b000001000000000,
    B_M1   = 15'b000010000000000,
    B_A1   = 15'b000100000000000,
    B_M2   = 15'b001000000000000,
    B_A2   = 15'b010000000000000,
    B_OUT  = 15'b100000000000000
  } bstate_t;

  bstate_t             state_r, state_nxt;
  sgb_cmd_t            cmd_r;
  logic                half_r;
  logic [DATA_W-1:0]   mem [DEPTH];
  logic [DATA_W-1:0]   rd_data_r;
  logic [DATA_W-1:0]   c0_r, c1_r, c2_r, c3_r;
  logic [DATA_W-1:0]   lower_r, upper_r, res_r;
  logic [49:0]         prod_r;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_value_r;
  logic                out_flip_r;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [PCNT_W-1:0]   rd_col;
  logic [TCNT_W-1:0]   rd_row;
  logic                wr_half;
  logic [DATA_W-1:0]   op_a, op_b;
  logic [ALPHA_W-1:0]  op_alpha;
  logic [DATA_W:0]     diff;
  logic [49:0]         sum;
  logic [33:0]         step;
  logic [DATA_W-1:0]   blend_res;
  logic                out_free;

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_pole_flipped = out_flip_r;
  assign out_free         = !out_valid_r || !out_stall;
  assign q_pop            = (state_r == B_IDLE) && !q_empty;

  // Cell address for each read slot of a sample.
  always_comb begin
    rd_col = cmd_r.col_lo;
    rd_row = cmd_r.row_lo;
    case (state_r)
      B_RD1: rd_col = cmd_r.col_hi;
      B_RD2: rd_row = cmd_r.row_hi;
      B_RD3: begin
        rd_col = cmd_r.col_hi;
        rd_row = cmd_r.row_hi;
      end
      default: ;
    endcase
  end

  assign wr_half = half_r ^ (cmd_r.act == ACT_WR_NXT);
  assign rd_addr = AW'(half_r) * AW'(BANK) + AW'(rd_row) * AW'(PHI_CELLS) + AW'(rd_col);
  assign wr_addr = AW'(wr_half) * AW'(BANK) + AW'(cmd_r.row_lo) * AW'(PHI_CELLS)
                 + AW'(cmd_r.col_lo);

  // Grid memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (state_r == B_WR) mem[wr_addr] <= cmd_r.value;
    rd_data_r <= mem[rd_addr];
  end

  // Blend operands follow the step of the sequence.
  always_comb begin
    op_a     = c0_r;
    op_b     = c1_r;
    op_alpha = cmd_r.alpha_phi;
    case (state_r)
      B_M1, B_A1: begin
        op_a = c2_r;
        op_b = c3_r;
      end
      B_M2, B_A2: begin
        op_a     = lower_r;
        op_b     = upper_r;
        op_alpha = cmd_r.alpha_theta;
      end
      default: ;
    endcase
  end

  // Blend: a + round((b - a) * alpha / 2^16), product registered first.
  assign diff      = {op_b[DATA_W-1], op_b} - {op_a[DATA_W-1], op_a};
  assign sum       = prod_r + 50'sd32768;
  assign step      = 34'($signed(sum) >>> 16);
  assign blend_res = op_a + step[DATA_W-1:0];

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          unique case (q_head.act)
            ACT_WR_CUR, ACT_WR_NXT: state_nxt = B_WR;
            ACT_SWAP:               state_nxt = B_SWAP;
            default:                state_nxt = B_RD0;
          endcase
        end
      end
      B_WR:   state_nxt = B_IDLE;
      B_SWAP: state_nxt = B_IDLE;
      B_RD0:  state_nxt = B_RD1;
      B_RD1:  state_nxt = (cmd_r.act == ACT_READ) ? B_OUT : B_RD2;
      B_RD2:  state_nxt = B_RD3;
      B_RD3:  state_nxt = B_RD4;
      B_RD4:  state_nxt = B_M0;
      B_M0:   state_nxt = B_A0;
      B_A0:   state_nxt = B_M1;
      B_M1:   state_nxt = B_A1;
      B_A1:   state_nxt = B_M2;
      B_M2:   state_nxt = B_A2;
      B_A2:   state_nxt = B_OUT;
      B_OUT:  if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_SWAP) half_r <= ~half_r;
      if (state_r == B_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_head;
    case (state_r)
      B_RD1: c0_r <= rd_data_r;
      B_RD2: c1_r <= rd_data_r;
      B_RD3: c2_r <= rd_data_r;
      B_RD4: c3_r <= rd_data_r;
      B_M0, B_M1, B_M2: prod_r <= 50'($signed(diff) * $signed({1'b0, op_alpha}));
      B_A0: lower_r <= blend_res;
      B_A1: upper_r <= blend_res;
      B_A2: res_r   <= blend_res;
      default: ;
    endcase
    if (state_r == B_OUT && out_free) begin
      out_value_r <= (cmd_r.act == ACT_READ) ? c0_r : res_r;
      out_flip_r  <= (cmd_r.act == ACT_READ) ? 1'b0 : cmd_r.flipped;
    end
  end

endmodule

// ----- hdl/sphere_grid_bilinear_sampler.sv -----
// Top level of the sphere grid bilinear sampler.
// A write or swap beat is accepted, its command is handed over to the queue,
// and the back end takes it and then writes the cell or swaps the banks. A
// cell read passes the queue and the back end states B_RD0, B_RD1 and B_OUT.
// A sample beat holds the input while the front end reflects the angles on
// acceptance, scales both angles, runs the column-modulo unit one step per
// index bit, and hands the command over. The back end then takes the command,
// makes the four reads of the grid memory through its one registered read
// port, runs three blends, each a multiply and an add step, on one shared
// multiplier, and loads the result register. Front and back overlap through a
// two-entry queue, so the front can take the next beat while the back end is
// busy with the last. The grid memory is not cleared; cells must be written
// before they are read.
`timescale 1ns / 1ps
module sphere_grid_bilinear_sampler import sgb_pkg::*; #(
  parameter int PHI_CELLS   = 128,
  parameter int THETA_CELLS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CPT_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ACT_W-1:0]     in_action,
  input  logic [COL_W-1:0]     in_col,
  input  logic [ROW_W-1:0]     in_row,
  input  logic [DATA_W-1:0]    in_value,
  input  logic [ANGLE_W-1:0]   in_phi_angle,
  input  logic [ANGLE_W-1:0]   in_theta_angle,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_W-1:0]    out_result_value,
  output logic                 out_pole_flipped
);

  localparam int PCNT_MAX = (PHI_CELLS > 255) ? 255 : PHI_CELLS;
  localparam int TCNT_MAX = (THETA_CELLS > 127) ? 127 : THETA_CELLS;

  logic [CPT_W-1:0]  cpt_r;
  logic [PCNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [TCNT_W-1:0] tcnt_r, tcnt_nxt;
  logic              push, q_full, q_pop, q_empty;
  sgb_cmd_t          push_cmd, q_head;

  // Count registers clamp to one and to the grid size.
  always_comb begin
    pcnt_nxt = cfg_data[PCNT_W-1:0];
    if (pcnt_nxt == '0) pcnt_nxt = PCNT_W'(1);
    if (32'(pcnt_nxt) > PCNT_MAX) pcnt_nxt = PCNT_W'(PCNT_MAX);
    tcnt_nxt = cfg_data[TCNT_W-1:0];
    if (tcnt_nxt == '0) tcnt_nxt = TCNT_W'(1);
    if (32'(tcnt_nxt) > TCNT_MAX) tcnt_nxt = TCNT_W'(TCNT_MAX);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpt_r  <= CPT_RESET;
      pcnt_r <= PCNT_W'(PCNT_MAX);
      tcnt_r <= TCNT_W'(TCNT_MAX);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CPT:  cpt_r  <= cfg_data;
        CFG_PCNT: pcnt_r <= pcnt_nxt;
        CFG_TCNT: tcnt_r <= tcnt_nxt;
        default: ;
      endcase
    end
  end

  sgb_front #(
    .PHI_CELLS   (PHI_CELLS),
    .THETA_CELLS (THETA_CELLS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_value       (in_value),
    .in_phi_angle   (in_phi_angle),
    .in_theta_angle (in_theta_angle),
    .cells_per_turn (cpt_r),
    .phi_count      (pcnt_r),
    .theta_count    (tcnt_r),
    .push           (push),
    .push_cmd       (push_cmd),
    .q_full         (q_full)
  );

  sgb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  sgb_back #(
    .PHI_CELLS   (PHI_CELLS),
    .THETA_CELLS (THETA_CELLS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_pole_flipped (out_pole_flipped)
  );

endmodule

// ----- hdl/sgb_checker.sv -----
// Port-level checks for the sphere grid bilinear sampler, bound to the top level.
`timescale 1ns / 1ps
module sgb_checker import sgb_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic [ACT_W-1:0] in_action,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_pole_flipped
);

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  // A stalled result beat stays offered.
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> (out_valid || !rst_n))
    else $error("result beat dropped while stalled");

  // The pole flag of a stalled result beat does not change.
  a_flip_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> ($stable(out_pole_flipped) || !rst_n))
    else $error("pole flag changed while stalled");

  // A sample beat keeps the front busy for its scaling and modulo steps.
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == ACT_SAMPLE |=> (in_stall || !rst_n))
    else $error("front took a beat while a sample was in work");

  // No result can appear in the cycle after reset is released.
  a_no_early_out: assert property (@(posedge clk)
    !rst_n ##1 rst_n |-> !out_valid)
    else $error("result beat before any work");

endmodule

bind sphere_grid_bilinear_sampler sgb_checker u_sgb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_action        (in_action),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pole_flipped (out_pole_flipped)
);

// ----- tb/sphere_grid_bilinear_sampler_tb.sv -----
// Self-checking testbench for the sphere grid bilinear sampler.
`timescale 1ns / 1ps
module sphere_grid_bilinear_sampler_tb;
  import sgb_pkg::*;

  localparam int NCOL = 128;
  localparam int NROW = 64;
  localparam int BANK = NCOL * NROW;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [ACT_W-1:0]   action;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [DATA_W-1:0]  value;
    logic [ANGLE_W-1:0] phi;
    logic [ANGLE_W-1:0] theta;
  } grid_op_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              flipped;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CPT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ACT_W-1:0] in_action = '0;
  logic [COL_W-1:0] in_col = '0;
  logic [ROW_W-1:0] in_row = '0;
  logic [DATA_W-1:0] in_value = '0;
  logic [ANGLE_W-1:0] in_phi_angle = '0;
  logic [ANGLE_W-1:0] in_theta_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DATA_W-1:0] out_result_value;
  logic out_pole_flipped;

  sphere_grid_bilinear_sampler dut (.*);

  always #2 clk = ~clk;

  // Shadow of the block: grid banks, bank select, registers.
  logic [DATA_W-1:0] grid_mirror [2*BANK];
  bit bank_sel;
  logic [CPT_W-1:0] scale_q;
  int unsigned col_span;
  int unsigned row_span;

  grid_op_t op_queue[$];
  sample_t expected_samples[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned result_count;
  longint cycle_count;

  function automatic int unsigned cell_index(bit half, int unsigned c, int unsigned r);
    return half * BANK + (r % NROW) * NCOL + (c % NCOL);
  endfunction

  // Rounded lerp in 64-bit signed arithmetic; floor via arithmetic shift.
  function automatic logic signed [31:0] lerp_q16(logic signed [31:0] a,
                                                  logic signed [31:0] b,
                                                  logic [15:0] w);
    longint p;
    p = (longint'(b) - longint'(a)) * longint'({16'd0, w}) + 64'sd32768;
    return 32'(longint'(a) + (p >>> 16));
  endfunction

  // Applies one accepted beat to the shadow and queues any expected result.
  task automatic predict_grid_op(grid_op_t op);
    sample_t s;
    logic [31:0] ph, th;
    logic [63:0] np, nt;
    int unsigned pidx, tidx, plo, phi_hi, tlo, thi, last;
    logic signed [31:0] lower, upper;
    case (op.action)
      ACT_WR_CUR, ACT_WR_NXT: begin
        grid_mirror[cell_index(bank_sel ^ op.action[0], op.col, op.row)] = op.value;
      end
      ACT_SWAP: bank_sel = ~bank_sel;
      ACT_READ: begin
        s.value = grid_mirror[cell_index(bank_sel, op.col, op.row)];
        s.flipped = 1'b0;
        expected_samples.push_back(s);
      end
      ACT_SAMPLE: begin
        ph = op.phi;
        th = op.theta;
        s.flipped = 1'b0;
        if (th > 32'h8000_0000) begin
          th = 32'd0 - th;
          ph = ph + 32'h8000_0000;
          s.flipped = 1'b1;
        end
        np = 64'(ph) * 64'(scale_q);
        nt = 64'(th) * 64'(scale_q);
        pidx = np[63:40];
        tidx = nt[63:40];
        plo = pidx % col_span;
        phi_hi = (plo + 1) % col_span;
        last = row_span - 1;
        tlo = tidx > last ? last : tidx;
        thi = tidx + 1 > last ? last : tidx + 1;
        lower = lerp_q16(grid_mirror[cell_index(bank_sel, plo, tlo)],
                         grid_mirror[cell_index(bank_sel, phi_hi, tlo)], np[39:24]);
        upper = lerp_q16(grid_mirror[cell_index(bank_sel, plo, thi)],
                         grid_mirror[cell_index(bank_sel, phi_hi, thi)], np[39:24]);
        s.value = lerp_q16(lower, upper, nt[39:24]);
        expected_samples.push_back(s);
      end
      default: ;
    endcase
  endtask

  // Input driver: presents queued beats, holds them while stalled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (in_valid) begin
          predict_grid_op(op_queue.pop_front());
        end
        if (op_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_action <= op_queue[0].action;
          in_col <= op_queue[0].col;
          in_row <= op_queue[0].row;
          in_value <= op_queue[0].value;
          in_phi_angle <= op_queue[0].phi;
          in_theta_angle <= op_queue[0].theta;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and random receiver stall.
  always @(posedge clk) begin
    sample_t s;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (expected_samples.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("unexpected result beat: value %h flipped %b",
                     out_result_value, out_pole_flipped);
        end else begin
          s = expected_samples.pop_front();
          if (s.value !== out_result_value || s.flipped !== out_pole_flipped) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("result mismatch: expected %h/%b got %h/%b", s.value, s.flipped,
                       out_result_value, out_pole_flipped);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Run limit.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Configuration write on an idle block; the shadow follows the same clamping.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CPT_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CPT: scale_q = data;
      CFG_PCNT: col_span = data[7:0] == 0 ? 1 : (data[7:0] > NCOL ? NCOL : data[7:0]);
      CFG_TCNT: row_span = data[6:0] == 0 ? 1 : (data[6:0] > NROW ? NROW : data[6:0]);
      default: ;
    endcase
  endtask

  function automatic grid_op_t make_op(logic [ACT_W-1:0] a, int unsigned c, int unsigned r,
                                       logic [31:0] v, logic [31:0] ph, logic [31:0] th);
    grid_op_t op;
    op.action = a;
    op.col = COL_W'(c);
    op.row = ROW_W'(r);
    op.value = v;
    op.phi = ph;
    op.theta = th;
    return op;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Queues writes of both banks over the cells that reads and samples reach:
  // the whole first row, the whole first column and a 16 by 8 corner block.
  task automatic fill_both_banks();
    for (int r = 0; r < NROW; r++)
      for (int c = 0; c < NCOL; c++) begin
        if (r == 0 || c == 0 || (c < 16 && r < 8)) begin
          op_queue.push_back(make_op(ACT_WR_CUR, c, r, rand_value(), $urandom, $urandom));
          op_queue.push_back(make_op(ACT_WR_NXT, c, r, rand_value(), $urandom, $urandom));
        end
      end
  endtask

  function automatic logic [31:0] rand_theta();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h8000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // Reads stay inside the corner block, which every bank holds.
  function automatic grid_op_t rand_op();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45)
      return make_op(ACT_SAMPLE, $urandom, $urandom, $urandom, $urandom, rand_theta());
    if (pick < 65)
      return make_op(ACT_READ, $urandom_range(15), $urandom_range(7), $urandom, $urandom,
                     $urandom);
    if (pick < 85)
      return make_op(pick[0] ? ACT_WR_NXT : ACT_WR_CUR, $urandom, $urandom, rand_value(),
                     $urandom, $urandom);
    if (pick < 95)
      return make_op(ACT_SWAP, $urandom, $urandom, $urandom, $urandom, $urandom);
    return make_op(ACT_W'($urandom_range(7, 5)), $urandom, $urandom, $urandom, $urandom,
                   $urandom);
  endfunction

  // Waits until every queued beat is taken and every result has come back.
  task automatic drain();
    while (op_queue.size() > 0 || in_valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    bank_sel = 1'b0;
    scale_q = CPT_RESET;
    col_span = NCOL;
    row_span = NROW;
    mismatch_count = 0;
    result_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: fill both banks; reads, swaps, writes; 16 by 8 corner samples.
    write_reg(CFG_PCNT, 21'd16);
    write_reg(CFG_TCNT, 21'd8);
    fill_both_banks();
    op_queue.push_back(make_op(ACT_READ, 127, 0, 0, 0, 0));
    op_queue.push_back(make_op(ACT_READ, 0, 0, 0, 0, 0));
    op_queue.push_back(make_op(ACT_SAMPLE, 0, 0, 0, 32'h0, 32'h0));
    op_queue.push_back(make_op(ACT_SAMPLE, 0, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000));
    op_queue.push_back(make_op(ACT_SAMPLE, 0, 0, 0, 32'h1234_5678, 32'h8000_0001));
    op_queue.push_back(make_op(ACT_SAMPLE, 0, 0, 0, 32'h8000_0000, 32'hFFFF_FFFF));
    op_queue.push_back(make_op(ACT_SWAP, 0, 0, 0, 0, 0));
    op_queue.push_back(make_op(ACT_READ, 5, 7, 0, 0, 0));
    op_queue.push_back(make_op(ACT_WR_NXT, 127, 63, 32'h7FFF_FFFF, 0, 0));
    op_queue.push_back(make_op(ACT_WR_CUR, 0, 0, 32'h8000_0000, 0, 0));
    op_queue.push_back(make_op(ACT_SAMPLE, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    op_queue.push_back(make_op(3'd7, 0, 0, 0, 0, 0));
    op_queue.push_back(make_op(ACT_SWAP, 0, 0, 0, 0, 0));
    op_queue.push_back(make_op(ACT_READ, 127, 63, 0, 0, 0));
    drain();

    // Random phases over register settings, including the extremes. Each
    // setting keeps samples on cells that were filled.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 64; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 64; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      case (phase)
        0: begin write_reg(CFG_CPT, 21'd256); write_reg(CFG_PCNT, 21'd1);
                 write_reg(CFG_TCNT, 21'd1); end
        1: begin write_reg(CFG_CPT, 21'd1048576); write_reg(CFG_PCNT, 21'd255);
                 write_reg(CFG_TCNT, 21'd1); end
        2: begin write_reg(CFG_CPT, 21'h1F_FFFF); write_reg(CFG_PCNT, 21'd0);
                 write_reg(CFG_TCNT, 21'd127); end
        3: begin write_reg(CFG_CPT, 21'd0); write_reg(CFG_PCNT, 21'd0);
                 write_reg(CFG_TCNT, 21'd0); end
        4: begin write_reg(CFG_CPT, 21'd32768); write_reg(CFG_PCNT, 21'd13);
                 write_reg(CFG_TCNT, 21'd7); end
        default: begin
          write_reg(CFG_CPT, CPT_W'($urandom_range(1048576, 256)));
          write_reg(CFG_PCNT, CPT_W'($urandom_range(16, 1)));
          write_reg(CFG_TCNT, CPT_W'($urandom_range(8, 1)));
        end
      endcase
      for (int k = 0; k < 85; k++) op_queue.push_back(rand_op());
      drain();
    end

    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/sgb_pkg.sv
hdl/sgb_front.sv
hdl/sgb_queue.sv
hdl/sgb_back.sv
hdl/sphere_grid_bilinear_sampler.sv
hdl/sgb_checker.sv
tb/sphere_grid_bilinear_sampler_tb.sv
